[sv/bounded_stable_priority_queue_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the bounded stable priority queue
// Immediate-cycle and next-cycle implication checks, reset qualified.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BOUNDED_STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define BSPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bspq assertion failed");

// consequent holds in the cycle after the antecedent
`define BSPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bspq assertion failed");

`endif

[sv/bspq_pkg.sv]
// ----------------------------------------------------------------------------
// bspq_pkg
// Shared widths, defaults, command codes and cell control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bspq_pkg;

  localparam int unsigned PRIO_W          = 32;
  localparam int unsigned TAG_IN_W        = 16;
  localparam int unsigned CAP_W           = 5;
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned TAG_BITS_DEF    = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

[sv/bounded_stable_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// bounded_stable_priority_queue_top
// Sorted priority queue of up to MAX_ENTRIES entries built as a row of cells.
// Input channel (in_valid_i / in_stall_o) carries cmd, priority and tag;
// output channel (out_valid_o / out_stall_i) returns one result per
// transaction: accepted flag, head entry after the operation, entry count.
// An insert lands before the first entry of strictly lower priority, so equal
// priorities leave in arrival order. A remove drops the head.
// All cells compare and shift in the cycle of acceptance and the result
// is valid the next cycle. Throughput is 1 transaction per cycle while
// the receiver does not stall. A stalled result holds and blocks new
// input until it is taken.
// The capacity register (cfg_valid_i / cfg_ready_o) limits inserts; values
// above MAX_ENTRIES saturate. Reset empties the queue, sets capacity to 16
// and clears the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_stable_priority_queue_top
  import bspq_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned TAG_BITS    = TAG_BITS_DEF,
  localparam int unsigned CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CAP_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     cmd_i,
  input  logic signed [PRIO_W-1:0] priority_req_i,
  input  logic [TAG_IN_W-1:0]      task_tag_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     accepted_o,
  output logic                     head_valid_o,
  output logic signed [PRIO_W-1:0] head_priority_o,
  output logic [TAG_IN_W-1:0]      head_tag_o,
  output logic [CNT_W-1:0]         entry_count_o
);

  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             accepted_q, accepted_d;
  logic             in_accept, full, ins_ok, rem_ok;
  cell_ctl_t        ctl;
  logic [TAG_BITS-1:0] new_tag;

  logic                     valid_w [MAX_ENTRIES];
  logic signed [PRIO_W-1:0] prio_w  [MAX_ENTRIES];
  logic [TAG_BITS-1:0]      tag_w   [MAX_ENTRIES];
  logic                     take_w  [MAX_ENTRIES];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;

  assign full = (count_q >= CNT_W'(MAX_ENTRIES)) ||
                (CMP_W'(count_q) >= CMP_W'(capacity_q));
  assign ins_ok = in_accept && (cmd_e'(cmd_i) == CMD_INSERT) && !full;
  assign rem_ok = in_accept && (cmd_e'(cmd_i) == CMD_REMOVE) && (count_q != '0);

  assign ctl.ins = ins_ok;
  assign ctl.rem = rem_ok;
  assign new_tag = TAG_BITS'({{TAG_BITS{1'b0}}, task_tag_i});

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic                     left_take, left_valid, right_valid;
    logic signed [PRIO_W-1:0] left_prio, right_prio;
    logic [TAG_BITS-1:0]      left_tag, right_tag;

    if (i == 0) begin : g_first
      assign left_take  = 1'b0;
      assign left_valid = 1'b0;
      assign left_prio  = '0;
      assign left_tag   = '0;
    end else begin : g_mid
      assign left_take  = take_w[i-1];
      assign left_valid = valid_w[i-1];
      assign left_prio  = prio_w[i-1];
      assign left_tag   = tag_w[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_prio  = '0;
      assign right_tag   = '0;
    end else begin : g_inner
      assign right_valid = valid_w[i+1];
      assign right_prio  = prio_w[i+1];
      assign right_tag   = tag_w[i+1];
    end

    bspq_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .new_prio_i   (priority_req_i),
      .new_tag_i    (new_tag),
      .left_take_i  (left_take),
      .left_valid_i (left_valid),
      .left_prio_i  (left_prio),
      .left_tag_i   (left_tag),
      .right_valid_i(right_valid),
      .right_prio_i (right_prio),
      .right_tag_i  (right_tag),
      .valid_o      (valid_w[i]),
      .prio_o       (prio_w[i]),
      .tag_o        (tag_w[i]),
      .take_o       (take_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (rem_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    accepted_d  = accepted_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
      accepted_d  = ins_ok || rem_ok;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        capacity_q <= cfg_data_i;
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    accepted_q <= accepted_d;
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign entry_count_o   = count_q;
  assign head_valid_o    = valid_w[0];
  assign head_priority_o = valid_w[0] ? prio_w[0] : '0;
  assign head_tag_o      = valid_w[0] ? TAG_IN_W'({{TAG_IN_W{1'b0}}, tag_w[0]}) : '0;

endmodule

[sv/bspq_cell.sv]
// ----------------------------------------------------------------------------
// bspq_cell
// One slot of the sorted chain: holds an entry, takes the new entry, its left
// neighbor's entry on insert, or its right neighbor's entry on remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bspq_cell
  import bspq_pkg::*;
#(
  parameter int unsigned TAG_BITS = TAG_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctl_t                ctl_i,
  input  logic signed [PRIO_W-1:0] new_prio_i,
  input  logic [TAG_BITS-1:0]      new_tag_i,
  input  logic                     left_take_i,
  input  logic                     left_valid_i,
  input  logic signed [PRIO_W-1:0] left_prio_i,
  input  logic [TAG_BITS-1:0]      left_tag_i,
  input  logic                     right_valid_i,
  input  logic signed [PRIO_W-1:0] right_prio_i,
  input  logic [TAG_BITS-1:0]      right_tag_i,
  output logic                     valid_o,
  output logic signed [PRIO_W-1:0] prio_o,
  output logic [TAG_BITS-1:0]      tag_o,
  output logic                     take_o
);

  logic                     valid_q, valid_d;
  logic signed [PRIO_W-1:0] prio_q, prio_d;
  logic [TAG_BITS-1:0]      tag_q, tag_d;

  assign take_o = !valid_q || (prio_q < new_prio_i);

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    tag_d   = tag_q;
    if (ctl_i.rem) begin
      valid_d = right_valid_i;
      prio_d  = right_prio_i;
      tag_d   = right_tag_i;
    end else if (ctl_i.ins && take_o) begin
      if (left_take_i) begin
        valid_d = left_valid_i;
        prio_d  = left_prio_i;
        tag_d   = left_tag_i;
      end else begin
        valid_d = 1'b1;
        prio_d  = new_prio_i;
        tag_d   = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign valid_o = valid_q;
  assign prio_o  = prio_q;
  assign tag_o   = tag_q;

endmodule

[sv/bspq_checker.sv]
// ----------------------------------------------------------------------------
// bspq_checker
// Port-level checks of the priority queue results, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bounded_stable_priority_queue_top_macros.svh"

module bspq_checker
  import bspq_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  localparam int unsigned CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     accepted_o,
  input logic                     head_valid_o,
  input logic signed [PRIO_W-1:0] head_priority_o,
  input logic [TAG_IN_W-1:0]      head_tag_o,
  input logic [CNT_W-1:0]         entry_count_o
);

  `BSPQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(accepted_o) && $stable(head_priority_o) && $stable(head_tag_o) && $stable(entry_count_o))
  `BSPQ_ASSERT_NXT(a_result_follows, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)
  `BSPQ_ASSERT_IMP(a_head_matches_count, clk_i, rst_ni, out_valid_o, head_valid_o == (entry_count_o != '0))
  `BSPQ_ASSERT_IMP(a_empty_head_zero, clk_i, rst_ni, out_valid_o && !head_valid_o, (head_priority_o == '0) && (head_tag_o == '0))
  `BSPQ_ASSERT_IMP(a_count_bound, clk_i, rst_ni, out_valid_o, entry_count_o <= CNT_W'(MAX_ENTRIES))

endmodule

bind bounded_stable_priority_queue_top bspq_checker #(
  .MAX_ENTRIES(MAX_ENTRIES)
) u_bspq_checker (.*);
